FILE: src/sobel_edge_magnitude_defines.svh
// assertion macros shared by the sobel edge magnitude rtl
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SOBEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SOBEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sobel_pkg.sv
// package with the types, constants and functions of the sobel edge magnitude block
`default_nettype none

package sobel_pkg;

   localparam int PIXEL_W      = 8;
   localparam int CFG_WIDTH_W  = 9;
   localparam int CFG_HEIGHT_W = 11;
   localparam int CSR_DATA_W   = 11;
   localparam int ROW_W        = 10;
   localparam int GRAD_W       = 11;
   localparam int MAG_W        = 11;

   localparam int MIN_DIM      = 3;
   localparam int HEIGHT_CAP   = 1024;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 9'd16;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 11'd16;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // |gx| + |gy| saturated to one byte
   function automatic pixel_type edge_mag(input logic signed [GRAD_W-1:0] gx,
                                          input logic signed [GRAD_W-1:0] gy);
      logic [GRAD_W-1:0] ax;
      logic [GRAD_W-1:0] ay;
      logic [MAG_W-1:0]  sum;
      ax  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
      ay  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
      sum = MAG_W'(ax + ay);
      return (sum > MAG_W'(255)) ? 8'hFF : sum[PIXEL_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: src/sobel_edge_magnitude.sv
// sobel 3x3 edge magnitude over a raster pixel stream, two line memories
// a result passes the stage 1 register and then the output register before it shows on rsp_
// throughput: one pixel per cycle, set by one read and one write back per line memory
// per pixel; an input stalls only while a result waits in the output register
// reset clears counters, window, config (16 x 16) and valids; line memories stay unset
`default_nettype none
`include "sobel_edge_magnitude_defines.svh"

module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [sobel_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [sobel_pkg::PIXEL_W-1:0]         rsp_edge_res,
   output logic                                  rsp_last_of_frame,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire sobel_pkg::csr_index_type         csr_index,
   input  wire logic [sobel_pkg::CSR_DATA_W-1:0] csr_data
);
   import sobel_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;

   // configuration
   logic [CFG_WIDTH_W-1:0]  width_cfg_ff;
   logic [CFG_HEIGHT_W-1:0] height_cfg_ff;

   // frame position
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // effective frame size
   logic [EW-1:0]           w_ext;
   logic [EW-1:0]           w_eff;
   logic [EW-1:0]           w_last;
   logic [CFG_HEIGHT_W-1:0] h_eff;
   logic [CFG_HEIGHT_W-1:0] h_last_full;
   logic [ROW_W-1:0]        h_last;
   logic                    line_end;
   logic                    frame_end;
   logic                    accept;

   // line memories
   pixel_type line_above_mem     [MAX_WIDTH];
   pixel_type line_two_above_mem [MAX_WIDTH];

   // stage 1: read data back, window math
   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   pixel_type     s1_pixel_ff;
   pixel_type     top_rd_ff;
   pixel_type     mid_rd_ff;
   logic          s1_advance;

   // two previous window columns
   pixel_type win_t0_ff, win_m0_ff, win_b0_ff;
   pixel_type win_t1_ff, win_m1_ff, win_b1_ff;

   logic [GRAD_W-1:0]        col_right;
   logic [GRAD_W-1:0]        col_left;
   logic [GRAD_W-1:0]        row_top;
   logic [GRAD_W-1:0]        row_bot;
   logic signed [GRAD_W-1:0] gx;
   logic signed [GRAD_W-1:0] gy;
   pixel_type                mag;

   // output register
   logic      out_valid_ff, out_valid_in;
   pixel_type out_res_ff;
   logic      out_last_ff;
   logic      out_load;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_data[CFG_HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_ext = EW'(width_cfg_ff);
      if (w_ext < EW'(MIN_DIM)) begin
         w_eff = EW'(MIN_DIM);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      w_last = w_eff - EW'(1);

      if (height_cfg_ff < CFG_HEIGHT_W'(MIN_DIM)) begin
         h_eff = CFG_HEIGHT_W'(MIN_DIM);
      end else if (height_cfg_ff > CFG_HEIGHT_W'(HEIGHT_CAP)) begin
         h_eff = CFG_HEIGHT_W'(HEIGHT_CAP);
      end else begin
         h_eff = height_cfg_ff;
      end
      h_last_full = h_eff - CFG_HEIGHT_W'(1);
      h_last      = h_last_full[ROW_W-1:0];
   end

   // ---------------------------------------------------------------- counters
   assign accept    = req_valid && !req_stall;
   assign line_end  = (EW'(col_ff) >= w_last);
   assign frame_end = line_end && (row_ff >= h_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line memories
   // read at accept, write back when the item leaves stage 1; consecutive items
   // always hit different columns, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff <= line_above_mem[col_ff];
      end
      if (s1_advance) begin
         line_above_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= line_two_above_mem[col_ff];
      end
      if (s1_advance) begin
         line_two_above_mem[s1_col_ff] <= mid_rd_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_ff;
         s1_pixel_ff <= req_pixel;
         s1_emit_ff  <= (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
         s1_last_ff  <= frame_end;
      end
   end

   // right column is top/mid read back plus the new pixel at the bottom
   always_comb begin
      col_right = GRAD_W'(top_rd_ff) + (GRAD_W'(mid_rd_ff) << 1) + GRAD_W'(s1_pixel_ff);
      col_left  = GRAD_W'(win_t0_ff) + (GRAD_W'(win_m0_ff) << 1) + GRAD_W'(win_b0_ff);
      row_top   = GRAD_W'(win_t0_ff) + (GRAD_W'(win_t1_ff) << 1) + GRAD_W'(top_rd_ff);
      row_bot   = GRAD_W'(win_b0_ff) + (GRAD_W'(win_b1_ff) << 1) + GRAD_W'(s1_pixel_ff);
      gx        = $signed(col_right - col_left);
      gy        = $signed(row_top - row_bot);
      mag       = edge_mag(gx, gy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_t0_ff <= '0;
         win_m0_ff <= '0;
         win_b0_ff <= '0;
         win_t1_ff <= '0;
         win_m1_ff <= '0;
         win_b1_ff <= '0;
      end else if (s1_advance) begin
         win_t0_ff <= win_t1_ff;
         win_m0_ff <= win_m1_ff;
         win_b0_ff <= win_b1_ff;
         win_t1_ff <= top_rd_ff;
         win_m1_ff <= mid_rd_ff;
         win_b1_ff <= s1_pixel_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   assign out_load = s1_advance && s1_emit_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_res_ff  <= mag;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_edge_res      = out_res_ff;
   assign rsp_last_of_frame = out_last_ff;

   // ---------------------------------------------------------------- assertions
   `SOBEL_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && frame_end,
      (row_ff == '0) && (col_ff == '0), "counters did not wrap at frame end")

   `SOBEL_ASSERT_NEXT(a_no_drop, clock, reset,
      s1_valid_ff && s1_emit_ff && out_valid_ff && rsp_stall,
      s1_valid_ff && s1_emit_ff, "pending result left stage 1 while output was full")

   `SOBEL_ASSERT_NEXT(a_window_shift, clock, reset, s1_advance,
      (win_t0_ff == $past(win_t1_ff)) && (win_b0_ff == $past(win_b1_ff)),
      "window columns did not shift")

   `SOBEL_ASSERT_NOW(a_stall_only_busy, clock, reset, req_stall,
      out_valid_ff && s1_emit_ff, "input stalled without a waiting result")

endmodule

`default_nettype wire
